// ===== rtl/bcd_countdown_seven_segment_scan_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the countdown display block.
// ----------------------------------------------------------------------------
`ifndef BCD_COUNTDOWN_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define BCD_COUNTDOWN_SEVEN_SEGMENT_SCAN_MACROS_SVH

// same-cycle implication
`define BCDCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcdcd assertion failed");

// next-cycle implication
`define BCDCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcdcd assertion failed");

`endif

// ===== rtl/bcdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdcd_pkg
// Constants, codes and the segment decoder for the countdown display.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdcd_pkg;

   localparam int SCANS_PER_STEP = 10;
   localparam int DIGITS         = 4;
   localparam int FRAME_LEN      = DIGITS * SCANS_PER_STEP;
   localparam int SLOT_W         = $clog2(FRAME_LEN);

   typedef logic [3:0] digit_type;
   typedef logic [7:0] seg_type;
   typedef logic [3:0] enable_type;

   // request kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // scan positions
   localparam logic [1:0] POS_HUNDREDS = 2'd0;
   localparam logic [1:0] POS_TENS     = 2'd1;
   localparam logic [1:0] POS_ONES     = 2'd2;
   localparam logic [1:0] POS_TENTHS   = 2'd3;

   // active-low digit enables
   localparam enable_type EN_HUNDREDS = 4'hE;
   localparam enable_type EN_TENS     = 4'hD;
   localparam enable_type EN_ONES     = 4'hB;
   localparam enable_type EN_TENTHS   = 4'h7;
   localparam enable_type EN_OFF      = 4'hF;

   localparam seg_type    SEG_DP      = 8'h80;
   localparam seg_type    SEG_BLANK   = 8'h00;
   localparam logic [3:0] STEP_RESET  = 4'd1;

   function automatic seg_type seg_of(input digit_type d);
      seg_type s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic digit_type dec1_mod10(input digit_type d);
      return (d == 4'd0) ? 4'd9 : 4'(d - 4'd1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bcd_countdown_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// bcd_countdown_seven_segment_scan
// Four-digit BCD countdown with a multiplexed seven-segment scan.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata start value, tuser load/tick
//   rsp      out  rsp_tvalid/tready     tdata segments+enable, tuser done
//   csr      in   csr_valid/ready       csr_data step
//
// One request per cycle; a tick's result is registered and appears the
// cycle after acceptance, a load gives no result. The single output
// register sets the rate: req_tready falls only while a result is held
// and rsp_tready is low. Synchronous reset blanks the display (done set)
// and sets step to one. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bcd_countdown_seven_segment_scan_macros.svh"

module bcd_countdown_seven_segment_scan (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] start_value
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] segments, [11:8] digit_enable, rest 0
   output logic             rsp_tuser,   // [0] done_res
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data     // [3:0] step
);
   import bcdcd_pkg::*;

   digit_type          hund_ff, hund_in;
   digit_type          tens_ff, tens_in;
   digit_type          ones_ff, ones_in;
   digit_type          tenth_ff, tenth_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               fin_ff, fin_in;
   logic [3:0]         step_ff, step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   seg_type            seg_ff, seg_in;
   enable_type         en_ff, en_in;
   logic               done_ff, done_in;

   logic               req_fire;
   logic               tick_fire;
   logic               load_fire;
   logic               last_slot;
   logic               all_zero;
   logic [3:0]         step_m;
   logic [4:0]         tenth_sub;
   logic [1:0]         ld_hund;
   logic [6:0]         ld_rem;
   logic [14:0]        ld_prod;
   digit_type          ld_tens;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign tick_fire  = req_fire && (req_tuser == FUNC_TICK);
   assign load_fire  = req_fire && (req_tuser == FUNC_LOAD);
   assign csr_ready  = 1'b1;

   assign last_slot  = (slot_ff == SLOT_W'(FRAME_LEN - 1));
   assign all_zero   = (hund_ff | tens_ff | ones_ff | tenth_ff) == 4'd0;
   assign step_m     = (step_ff >= 4'd10) ? 4'(step_ff - 4'd10) : step_ff;
   assign tenth_sub  = (tenth_ff >= step_m) ? 5'({1'b0, tenth_ff} - {1'b0, step_m})
                                            : 5'({1'b0, tenth_ff} + 5'd10 - {1'b0, step_m});

   // binary to BCD: hundreds by compare, tens by reciprocal multiply
   always_comb begin
      if (req_tdata >= 8'd200) begin
         ld_hund = 2'd2;
         ld_rem  = 7'(req_tdata - 8'd200);
      end else if (req_tdata >= 8'd100) begin
         ld_hund = 2'd1;
         ld_rem  = 7'(req_tdata - 8'd100);
      end else begin
         ld_hund = 2'd0;
         ld_rem  = req_tdata[6:0];
      end
   end
   assign ld_prod = 15'(ld_rem) * 15'd205;
   assign ld_tens = ld_prod[14:11];

   always_comb begin
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      ones_in  = ones_ff;
      tenth_in = tenth_ff;
      slot_in  = slot_ff;
      fin_in   = fin_ff;
      step_in  = csr_valid ? csr_data : step_ff;

      if (load_fire) begin
         hund_in  = {2'b00, ld_hund};
         tens_in  = ld_tens;
         ones_in  = 4'(ld_rem - 7'(ld_tens * 4'd10));
         tenth_in = 4'd0;
         slot_in  = '0;
         fin_in   = 1'b0;
      end else if (tick_fire && !fin_ff) begin
         if (last_slot) begin
            slot_in = '0;
            if (all_zero) begin
               fin_in = 1'b1;
            end else begin
               if ((tens_ff | ones_ff | tenth_ff) == 4'd0) begin
                  hund_in = dec1_mod10(hund_ff);
               end
               if ((ones_ff | tenth_ff) == 4'd0) begin
                  tens_in = dec1_mod10(tens_ff);
               end
               if (tenth_ff == 4'd0) begin
                  ones_in = dec1_mod10(ones_ff);
               end
               tenth_in = tenth_sub[3:0];
            end
         end else begin
            slot_in = SLOT_W'(slot_ff + 1'b1);
         end
      end
   end

   always_comb begin
      if (fin_ff) begin
         seg_in = SEG_BLANK;
         en_in  = EN_OFF;
      end else begin
         case (slot_ff[1:0])
            POS_HUNDREDS: begin
               seg_in = seg_of(hund_ff);
               en_in  = EN_HUNDREDS;
            end
            POS_TENS: begin
               seg_in = seg_of(tens_ff);
               en_in  = EN_TENS;
            end
            POS_ONES: begin
               seg_in = seg_of(ones_ff) | SEG_DP;
               en_in  = EN_ONES;
            end
            POS_TENTHS: begin
               seg_in = seg_of(tenth_ff);
               en_in  = EN_TENTHS;
            end
            default: begin
               seg_in = SEG_BLANK;
               en_in  = EN_OFF;
            end
         endcase
      end
      done_in = fin_in;
   end

   assign rsp_valid_in = tick_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hund_ff      <= '0;
         tens_ff      <= '0;
         ones_ff      <= '0;
         tenth_ff     <= '0;
         slot_ff      <= '0;
         fin_ff       <= 1'b1;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         hund_ff      <= hund_in;
         tens_ff      <= tens_in;
         ones_ff      <= ones_in;
         tenth_ff     <= tenth_in;
         slot_ff      <= slot_in;
         fin_ff       <= fin_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         seg_ff  <= seg_in;
         en_ff   <= en_in;
         done_ff <= done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, en_ff, seg_ff};
   assign rsp_tuser  = done_ff;

   `BCDCD_ASSERT_NOW(a_slot_range, clock, reset, 1'b1, slot_ff < SLOT_W'(FRAME_LEN))
   `BCDCD_ASSERT_NOW(a_digits_bcd, clock, reset, 1'b1,
      hund_ff <= 4'd9 && tens_ff <= 4'd9 && ones_ff <= 4'd9 && tenth_ff <= 4'd9)
   `BCDCD_ASSERT_NEXT(a_load_starts, clock, reset, load_fire,
      !fin_ff && slot_ff == '0 && tenth_ff == 4'd0)
   `BCDCD_ASSERT_NOW(a_blank_is_done, clock, reset,
      rsp_valid_ff && en_ff == EN_OFF, done_ff && seg_ff == SEG_BLANK)

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the countdown display scan request by request. A directed table
// covers blank after reset, a full pass of a zero count, the largest start
// value and a restart while counting. Random phases at several step
// settings, the extremes among them, follow with random idling on both
// channels. Results are compared with an independent predictor or a pinned row.
// ----------------------------------------------------------------------------

module testbench;
   import bcdcd_pkg::*;

   localparam int CYCLE_LIMIT   = 500_000;
   localparam int RANDOM_ITEMS  = 560;
   localparam int PHASE_ITEMS   = 100;
   localparam int SETTLE_CYCLES = 4;

   localparam seg_type DIGIT_GLYPH [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   typedef struct {
      seg_type    segments;
      enable_type digit_enable;
      logic       done;
   } display_type;

   typedef struct {
      logic        func;
      logic [7:0]  value;
      int          reps;
      bit          pinned;
      display_type shown;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] start_value
   logic        req_tuser  = 1'b0;    // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] segments, [11:8] digit_enable
   logic        rsp_tuser;            // [0] done_res
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data   = 4'd0;    // [3:0] step

   // predictor state
   logic [3:0] hund_d    = 4'd0;
   logic [3:0] tens_d    = 4'd0;
   logic [3:0] ones_d    = 4'd0;
   logic [3:0] tenth_d   = 4'd0;
   int         slot_idx  = 0;
   bit         stopped   = 1'b1;
   logic [3:0] step_val  = STEP_RESET;

   display_type display_q [$];
   bit          pin_on    = 1'b0;
   display_type pin_val;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          req_calm  = 1'b0;
   bit          rsp_calm  = 1'b0;
   int          rsp_hold  = 0;

   stim_row_type directed_rows [16] = '{
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{SEG_BLANK, EN_OFF,      1'b1}},
      '{FUNC_LOAD, 8'd0,    1, 1'b0, '{SEG_BLANK, EN_OFF,      1'b0}},
      '{FUNC_TICK, 8'hFF,   1, 1'b1, '{8'h3F,     EN_HUNDREDS, 1'b0}},
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{8'h3F,     EN_TENS,     1'b0}},
      '{FUNC_TICK, 8'hA5,   1, 1'b1, '{8'hBF,     EN_ONES,     1'b0}},
      '{FUNC_TICK, 8'h5A,   1, 1'b1, '{8'h3F,     EN_TENTHS,   1'b0}},
      '{FUNC_TICK, 8'h00,  35, 1'b0, '{SEG_BLANK, EN_OFF,      1'b0}},
      // last slot of the pass still shows its digit, and stops the count
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{8'h3F,     EN_TENTHS,   1'b1}},
      '{FUNC_TICK, 8'hFF,   1, 1'b1, '{SEG_BLANK, EN_OFF,      1'b1}},
      '{FUNC_LOAD, 8'd255,  1, 1'b0, '{SEG_BLANK, EN_OFF,      1'b0}},
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{8'h5B,     EN_HUNDREDS, 1'b0}},
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{8'h6D,     EN_TENS,     1'b0}},
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{8'hED,     EN_ONES,     1'b0}},
      '{FUNC_TICK, 8'h00,  40, 1'b0, '{SEG_BLANK, EN_OFF,      1'b0}},
      // reload mid-pass restarts at the hundreds slot
      '{FUNC_LOAD, 8'd128,  1, 1'b0, '{SEG_BLANK, EN_OFF,      1'b0}},
      '{FUNC_TICK, 8'h00,   1, 1'b1, '{8'h06,     EN_HUNDREDS, 1'b0}}
   };

   bcd_countdown_seven_segment_scan dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [3:0] minus_mod10(input logic [3:0] d, input logic [3:0] amt);
      int v;
      v = int'(d % 10) - int'(amt % 10);
      if (v < 0) begin
         v += 10;
      end
      return 4'(v);
   endfunction

   function automatic void advance_countdown(input logic func, input logic [7:0] value,
                                             output bit emits, output display_type res);
      logic [1:0] pos;
      logic [3:0] h, t, o, f;
      emits = 1'b0;
      res   = '{SEG_BLANK, EN_OFF, 1'b1};
      if (func == FUNC_LOAD) begin
         hund_d   = 4'(value / 100);
         tens_d   = 4'((value / 10) % 10);
         ones_d   = 4'(value % 10);
         tenth_d  = 4'd0;
         slot_idx = 0;
         stopped  = 1'b0;
         return;
      end
      emits = 1'b1;
      if (stopped) begin
         return;
      end
      pos = 2'(slot_idx % 4);
      case (pos)
         POS_HUNDREDS: begin
            res.segments = DIGIT_GLYPH[hund_d];   res.digit_enable = EN_HUNDREDS;
         end
         POS_TENS: begin
            res.segments = DIGIT_GLYPH[tens_d];   res.digit_enable = EN_TENS;
         end
         POS_ONES: begin
            res.segments = DIGIT_GLYPH[ones_d] | SEG_DP;
            res.digit_enable = EN_ONES;
         end
         default: begin
            res.segments = DIGIT_GLYPH[tenth_d];  res.digit_enable = EN_TENTHS;
         end
      endcase
      slot_idx++;
      if (slot_idx >= FRAME_LEN) begin
         slot_idx = 0;
         h = hund_d; t = tens_d; o = ones_d; f = tenth_d;
         if ((h | t | o | f) == 4'd0) begin
            stopped = 1'b1;
         end else begin
            if ((t | o | f) == 4'd0) hund_d = minus_mod10(h, 4'd1);
            if ((o | f) == 4'd0)     tens_d = minus_mod10(t, 4'd1);
            if (f == 4'd0)           ones_d = minus_mod10(o, 4'd1);
            tenth_d = minus_mod10(f, step_val);
         end
      end
      res.done = stopped;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic func, input logic [7:0] value,
                               input bit pinned, input display_type pin);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      pin_on = pinned;
      pin_val = pin;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic settle_display();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (display_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         rsp_calm = ~rsp_calm;
      end
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = pick_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin : check_display
      display_type seen, want, predicted;
      bit emits;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tdata[7:0], rsp_tdata[11:8], rsp_tuser};
            if (display_q.size() == 0) begin
               $error("unexpected result: segments %h digit_enable %h done_res %b",
                      seen.segments, seen.digit_enable, seen.done);
               mismatch_count++;
            end else begin
               want = display_q.pop_front();
               if (seen.segments !== want.segments) begin
                  $error("segments: expected %h, got %h", want.segments, seen.segments);
                  mismatch_count++;
               end
               if (seen.digit_enable !== want.digit_enable) begin
                  $error("digit_enable: expected %h, got %h",
                         want.digit_enable, seen.digit_enable);
                  mismatch_count++;
               end
               if (seen.done !== want.done) begin
                  $error("done_res: expected %b, got %b", want.done, seen.done);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            step_val = csr_data;
         end
         if (req_tvalid && req_tready) begin
            advance_countdown(req_tuser, req_tdata, emits, predicted);
            if (emits) begin
               display_q.push_back(pin_on ? pin_val : predicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      display_type none;
      logic [3:0]  phase_steps [5];
      int          issued, phase, phase_count, kind, ticks, r;
      logic [7:0]  start;

      phase_steps = '{4'd9, 4'd0, 4'd15, 4'd5, 4'd10};
      none = '{SEG_BLANK, EN_OFF, 1'b0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part runs at the reset step of one
      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            send_request(directed_rows[i].func, directed_rows[i].value,
                         directed_rows[i].pinned, directed_rows[i].shown);
         end
      end

      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS) begin
         settle_display();
         write_step(phase < 5 ? phase_steps[phase] : 4'($urandom_range(0, 15)));
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            req_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               r = $urandom_range(0, 99);
               if (r < 40)      start = 8'($urandom_range(0, 3));
               else if (r < 55) start = 8'(10 * $urandom_range(0, 25));
               else if (r < 65) start = 8'(100 * $urandom_range(0, 2));
               else             start = 8'($urandom_range(0, 255));
               send_request(FUNC_LOAD, start, 1'b0, none);
               ticks = 40 * $urandom_range(0, 2) + $urandom_range(1, 40);
            end else if (kind < 85) begin
               ticks = $urandom_range(1, 20);
            end else begin
               send_request(FUNC_LOAD, 8'($urandom_range(0, 255)), 1'b0, none);
               ticks = $urandom_range(0, 8);
            end
            phase_count += ticks + ((kind < 70 || kind >= 85) ? 1 : 0);
            repeat (ticks) begin
               send_request(FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, none);
            end
         end
         issued += phase_count;
         phase++;
      end

      settle_display();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
